@@ rtl/core/gcne_pkg.sv @@
// ----------------------------------------------------------------------------
// gcne_pkg
// Shared types, constants and helpers of the grid cell neighbor enumerator.
// ----------------------------------------------------------------------------
`default_nettype none

package gcne_pkg;

  localparam int MAX_CELLS = 256;
  localparam int RANK_W    = 8;
  localparam int DIM_W     = 9;
  localparam int SLOT_W    = 5;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int TOTAL_W   = 3 * DIM_W;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(26);

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_Z   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC = 2'd3;

  // index 0: offset -1, index 1: offset 0, index 2: offset +1
  typedef struct packed {
    logic [2:0]             ok;
    logic [2:0][RANK_W-1:0] c;
  } axis_nb_t;

  // one queued cell: per-axis neighbor rank terms and present bits
  typedef struct packed {
    logic                   valid;
    logic [2:0]             okx;
    logic [2:0]             oky;
    logic [2:0]             okz;
    logic [2:0][RANK_W-1:0] xc;
    logic [2:0][RANK_W-1:0] yc;
    logic [2:0][RANK_W-1:0] zc;
  } nb_entry_t;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_DIV  = 4'b0010,
    F_MUL  = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_t;

  function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] g);
    return (g == '0) ? DIM_W'(1) : g;
  endfunction

  function automatic axis_nb_t move_axis(input logic [RANK_W-1:0] c,
                                         input logic [DIM_W-1:0] g,
                                         input logic wrap);
    axis_nb_t         r;
    logic [DIM_W-1:0] gm1;
    logic             at_hi;
    gm1   = g - DIM_W'(1);
    at_hi = ({1'b0, c} + DIM_W'(1)) >= g;
    r.c[1]  = c;
    r.ok[1] = 1'b1;
    if (c == '0) begin
      r.ok[0] = wrap;
      r.c[0]  = gm1[RANK_W-1:0];
    end else begin
      r.ok[0] = 1'b1;
      r.c[0]  = c - RANK_W'(1);
    end
    if (at_hi) begin
      r.ok[2] = wrap;
      r.c[2]  = '0;
    end else begin
      r.ok[2] = 1'b1;
      r.c[2]  = c + RANK_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/gcne_front.sv @@
// ----------------------------------------------------------------------------
// gcne_front
// Holds the grid registers, takes cell requests, splits the rank into x/y/z
// with a two-bit-per-cycle divider and forms per-axis neighbor rank terms.
// ----------------------------------------------------------------------------
`default_nettype none

module gcne_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wen,
  input  wire logic [gcne_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gcne_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [gcne_pkg::RANK_W-1:0]      in_rank,
  output logic                                  push_valid,
  input  wire logic                             push_ready,
  output gcne_pkg::nb_entry_t                   push_data
);

  logic [gcne_pkg::DIM_W-1:0]   grid_x, grid_y, grid_z;
  logic [2:0]                   periodic;
  logic [gcne_pkg::DIM_W-1:0]   gx, gy, gz;

  logic                         hold_valid;
  logic [gcne_pkg::RANK_W-1:0]  hold_rank;

  gcne_pkg::front_state_t       state;
  logic [1:0]                   axis;
  logic [1:0]                   step;
  logic [2:0]                   mk;
  logic [gcne_pkg::RANK_W-1:0]  dvd, rem;
  logic [gcne_pkg::RANK_W-1:0]  px, py, pz;
  logic [2*gcne_pkg::DIM_W-1:0] plane;
  logic [gcne_pkg::TOTAL_W-1:0] total;
  logic [2:0][gcne_pkg::RANK_W-1:0] yc, zc;

  logic [gcne_pkg::DIM_W-1:0]   divisor;
  logic [gcne_pkg::DIM_W-1:0]   t1, t2, r1, r2;
  logic                         ge1, ge2;
  logic [gcne_pkg::RANK_W-1:0]  dvd1, dvd2;

  gcne_pkg::axis_nb_t           nbx, nby, nbz;
  logic [2:0]                   mk_z;
  logic [gcne_pkg::RANK_W-1:0]  mul_a, mul_b;
  logic [2*gcne_pkg::RANK_W-1:0] prod;

  assign gx = gcne_pkg::dim_of(grid_x);
  assign gy = gcne_pkg::dim_of(grid_y);
  assign gz = gcne_pkg::dim_of(grid_z);

  assign in_ready = !hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_x   <= gcne_pkg::DIM_W'(1);
      grid_y   <= gcne_pkg::DIM_W'(1);
      grid_z   <= gcne_pkg::DIM_W'(1);
      periodic <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        gcne_pkg::CFG_GRID_X:   grid_x   <= cfg_wdata;
        gcne_pkg::CFG_GRID_Y:   grid_y   <= cfg_wdata;
        gcne_pkg::CFG_GRID_Z:   grid_z   <= cfg_wdata;
        gcne_pkg::CFG_PERIODIC: periodic <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // restoring divide, two quotient bits per cycle
  always_comb begin
    case (axis)
      2'd0:    divisor = gx;
      2'd1:    divisor = gy;
      default: divisor = gz;
    endcase
    t1   = {rem, dvd[7]};
    ge1  = t1 >= divisor;
    r1   = ge1 ? (t1 - divisor) : t1;
    dvd1 = {dvd[6:0], ge1};
    t2   = {r1[gcne_pkg::RANK_W-1:0], dvd1[7]};
    ge2  = t2 >= divisor;
    r2   = ge2 ? (t2 - divisor) : t2;
    dvd2 = {dvd1[6:0], ge2};
  end

  assign nbx  = gcne_pkg::move_axis(px, gx, periodic[0]);
  assign nby  = gcne_pkg::move_axis(py, gy, periodic[1]);
  assign nbz  = gcne_pkg::move_axis(pz, gz, periodic[2]);
  assign mk_z = mk - 3'd3;

  always_comb begin
    if (mk < 3'd3) begin
      mul_a = nby.c[mk[1:0]];
      mul_b = gx[gcne_pkg::RANK_W-1:0];
    end else begin
      mul_a = nbz.c[mk_z[1:0]];
      mul_b = plane[gcne_pkg::RANK_W-1:0];
    end
    prod = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      state      <= gcne_pkg::F_IDLE;
      axis       <= '0;
      step       <= '0;
      mk         <= '0;
    end else begin
      if (in_valid && in_ready) begin
        hold_valid <= 1'b1;
      end
      case (state)
        gcne_pkg::F_IDLE: begin
          if (hold_valid) begin
            hold_valid <= 1'b0;
            axis       <= '0;
            step       <= '0;
            state      <= gcne_pkg::F_DIV;
          end
        end
        gcne_pkg::F_DIV: begin
          step <= step + 2'd1;
          if (step == 2'd3) begin
            if (axis == 2'd2) begin
              mk    <= '0;
              state <= gcne_pkg::F_MUL;
            end else begin
              axis <= axis + 2'd1;
            end
          end
        end
        gcne_pkg::F_MUL: begin
          mk <= mk + 3'd1;
          if (mk == 3'd5) begin
            state <= gcne_pkg::F_PUSH;
          end
        end
        gcne_pkg::F_PUSH: begin
          if (push_ready) begin
            state <= gcne_pkg::F_IDLE;
          end
        end
        default: state <= gcne_pkg::F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_rank <= in_rank;
    end
    case (state)
      gcne_pkg::F_IDLE: begin
        dvd   <= hold_rank;
        rem   <= '0;
        plane <= gx * gy;
      end
      gcne_pkg::F_DIV: begin
        total <= plane * gz;
        if (step == 2'd3) begin
          dvd <= dvd2;
          rem <= '0;
          case (axis)
            2'd0:    px <= r2[gcne_pkg::RANK_W-1:0];
            2'd1:    py <= r2[gcne_pkg::RANK_W-1:0];
            default: pz <= r2[gcne_pkg::RANK_W-1:0];
          endcase
        end else begin
          dvd <= dvd2;
          rem <= r2[gcne_pkg::RANK_W-1:0];
        end
      end
      gcne_pkg::F_MUL: begin
        if (mk < 3'd3) begin
          yc[mk[1:0]] <= prod[gcne_pkg::RANK_W-1:0];
        end else begin
          zc[mk_z[1:0]] <= prod[gcne_pkg::RANK_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign push_valid = (state == gcne_pkg::F_PUSH);

  always_comb begin
    push_data.valid = total <= gcne_pkg::TOTAL_W'(gcne_pkg::MAX_CELLS);
    push_data.okx   = nbx.ok;
    push_data.oky   = nby.ok;
    push_data.okz   = nbz.ok;
    push_data.xc    = nbx.c;
    push_data.yc    = yc;
    push_data.zc    = zc;
  end

endmodule

`default_nettype wire

@@ rtl/core/gcne_queue.sv @@
// ----------------------------------------------------------------------------
// gcne_queue
// Two-entry queue of classified cells between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module gcne_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push_valid,
  output logic                      push_ready,
  input  wire gcne_pkg::nb_entry_t  push_data,
  output logic                      pop_valid,
  input  wire logic                 pop_ready,
  output gcne_pkg::nb_entry_t       pop_data
);

  gcne_pkg::nb_entry_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/gcne_back.sv @@
// ----------------------------------------------------------------------------
// gcne_back
// Walks the 27 offsets of the queued cell, one per cycle while the output
// is not stalled, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gcne_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          pop_valid,
  output logic                               pop_ready,
  input  wire gcne_pkg::nb_entry_t           pop_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [gcne_pkg::SLOT_W-1:0]        out_slot,
  output logic [gcne_pkg::RANK_W-1:0]        out_rank,
  output logic                               out_present,
  output logic                               out_last
);

  logic [1:0]                  ix, iy, iz;
  logic [gcne_pkg::SLOT_W-1:0] slot;
  logic                        adv, ok, at_last;
  logic [gcne_pkg::RANK_W-1:0] rank;

  assign adv     = pop_valid && (!out_valid || out_ready);
  assign at_last = (slot == gcne_pkg::LAST_SLOT);
  assign pop_ready = adv && at_last;

  assign ok   = pop_data.valid && pop_data.okx[ix] && pop_data.oky[iy] && pop_data.okz[iz];
  assign rank = pop_data.xc[ix] + pop_data.yc[iy] + pop_data.zc[iz];

  always_ff @(posedge clk) begin
    if (rst) begin
      ix        <= '0;
      iy        <= '0;
      iz        <= '0;
      slot      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
        if (at_last) begin
          slot <= '0;
        end else begin
          slot <= slot + gcne_pkg::SLOT_W'(1);
        end
        if (ix == 2'd2) begin
          ix <= '0;
          if (iy == 2'd2) begin
            iy <= '0;
            iz <= (iz == 2'd2) ? 2'd0 : iz + 2'd1;
          end else begin
            iy <= iy + 2'd1;
          end
        end else begin
          ix <= ix + 2'd1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_slot    <= slot;
      out_rank    <= ok ? rank : '0;
      out_present <= ok;
      out_last    <= at_last;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/grid_cell_neighbor_enumerator.sv @@
// ----------------------------------------------------------------------------
// grid_cell_neighbor_enumerator
// Lists the 27 cells around a cell of a 3D grid, with per-axis wrap-around.
//
//   channel  dir  signals                      meaning
//   s_*      in   tvalid tready tdata[7:0]     cell request
//   m_*      out  tvalid tready tdata tuser    one neighbor, tlast on 27th
//   cfg_*    in   wen index[1:0] wdata[8:0]    grid_x grid_y grid_z periodic
//
// One request yields 27 results, one per cycle while the output is not
// stalled; the back end sets the request rate. The front end splits the
// rank with three divides, then forms the y and z terms with multiplies, and
// works on the next request while the back end emits. Reset is synchronous
// and leaves a 1x1x1 non-periodic grid. An output stall holds the back end;
// the queue and the input hold register let requests keep arriving meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_cell_neighbor_enumerator (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wen,
  input  wire logic [gcne_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gcne_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [7:0]                     s_tdata,   // [7:0] cell_rank
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [15:0]                         m_tdata,   // [4:0] slot, [12:5] neighbor_rank
  output logic                                m_tuser,   // [0] present
  output logic                                m_tlast
);

  logic                        push_valid, push_ready;
  logic                        pop_valid, pop_ready;
  gcne_pkg::nb_entry_t         push_data, pop_data;
  logic [gcne_pkg::SLOT_W-1:0] out_slot;
  logic [gcne_pkg::RANK_W-1:0] out_rank;

  gcne_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_rank    (s_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  gcne_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  gcne_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_slot    (out_slot),
    .out_rank    (out_rank),
    .out_present (m_tuser),
    .out_last    (m_tlast)
  );

  assign m_tdata = {3'b000, out_rank, out_slot};

endmodule

`default_nettype wire

@@ sim/grid_cell_neighbor_enumerator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_cell_neighbor_enumerator_tb
// Sends cell ranks to the enumerator under many grid shapes and wrap settings.
// Each of the 27 neighbor results is checked against a local model of the
// 3x3x3 walk, or against the row mask for typed table rows. A directed table
// runs first, then random phases; random input gaps and output stalls run throughout.
// ----------------------------------------------------------------------------
module grid_cell_neighbor_enumerator_tb;

  localparam logic [26:0] MASK_CENTER = 27'(1) << 13;
  localparam logic [26:0] MASK_ALL    = '1;
  localparam logic [26:0] MASK_NONE   = '0;
  localparam int          NUM_SLOTS   = 27;
  localparam int          DIR_N       = 24;
  localparam int          RAND_ITEMS  = 206;
  localparam int          HOLD_CYCLES = 600;

  typedef struct packed {
    logic [gcne_pkg::SLOT_W-1:0] slot;
    logic [gcne_pkg::RANK_W-1:0] rank;
    logic                        present;
    logic                        last;
  } nb_result_t;

  typedef struct packed {
    logic [gcne_pkg::DIM_W-1:0]  gx;
    logic [gcne_pkg::DIM_W-1:0]  gy;
    logic [gcne_pkg::DIM_W-1:0]  gz;
    logic [2:0]                  wrap;
    logic [gcne_pkg::RANK_W-1:0] rank;
    logic                        typed;
    logic [26:0]                 mask;
  } dir_row_t;

  // typed rows: every present neighbor has rank 0, absent ones give 0 too
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{9'd1,   9'd1,   9'd1,   3'd0, 8'd0,   1'b1, MASK_CENTER},
    '{9'd1,   9'd1,   9'd1,   3'd0, 8'd255, 1'b1, MASK_CENTER},
    '{9'd1,   9'd1,   9'd1,   3'd7, 8'd0,   1'b1, MASK_ALL},
    '{9'd0,   9'd0,   9'd0,   3'd0, 8'h5a,  1'b1, MASK_CENTER},
    '{9'd256, 9'd256, 9'd256, 3'd7, 8'd255, 1'b1, MASK_NONE},
    '{9'd511, 9'd1,   9'd1,   3'd0, 8'd1,   1'b1, MASK_NONE},
    '{9'd16,  9'd16,  9'd1,   3'd0, 8'd0,   1'b0, MASK_NONE},
    '{9'd16,  9'd16,  9'd1,   3'd0, 8'd255, 1'b0, MASK_NONE},
    '{9'd16,  9'd16,  9'd1,   3'd0, 8'h55,  1'b0, MASK_NONE},
    '{9'd16,  9'd16,  9'd1,   3'd3, 8'd0,   1'b0, MASK_NONE},
    '{9'd16,  9'd16,  9'd1,   3'd3, 8'd255, 1'b0, MASK_NONE},
    '{9'd16,  9'd16,  9'd1,   3'd3, 8'd17,  1'b0, MASK_NONE},
    '{9'd4,   9'd4,   9'd16,  3'd7, 8'd0,   1'b0, MASK_NONE},
    '{9'd4,   9'd4,   9'd16,  3'd7, 8'd255, 1'b0, MASK_NONE},
    '{9'd4,   9'd4,   9'd16,  3'd7, 8'd100, 1'b0, MASK_NONE},
    '{9'd256, 9'd1,   9'd1,   3'd1, 8'd0,   1'b0, MASK_NONE},
    '{9'd256, 9'd1,   9'd1,   3'd1, 8'd255, 1'b0, MASK_NONE},
    '{9'd1,   9'd256, 9'd1,   3'd2, 8'd0,   1'b0, MASK_NONE},
    '{9'd1,   9'd256, 9'd1,   3'd2, 8'd128, 1'b0, MASK_NONE},
    '{9'd1,   9'd1,   9'd256, 3'd4, 8'd255, 1'b0, MASK_NONE},
    '{9'd3,   9'd5,   9'd7,   3'd5, 8'd200, 1'b0, MASK_NONE},
    '{9'd3,   9'd5,   9'd7,   3'd5, 8'd104, 1'b0, MASK_NONE},
    '{9'd2,   9'd2,   9'd2,   3'd6, 8'd3,   1'b0, MASK_NONE},
    '{9'd0,   9'd16,  9'd0,   3'd2, 8'haa,  1'b0, MASK_NONE}
  };

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           cfg_wen   = 1'b0;
  logic [gcne_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gcne_pkg::CFG_W-1:0]     cfg_wdata = '0;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [7:0]                     s_tdata   = '0;  // [7:0] cell_rank
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [15:0]                    m_tdata;         // [4:0] slot, [12:5] neighbor_rank
  logic                           m_tuser;         // [0] present
  logic                           m_tlast;

  logic [gcne_pkg::DIM_W-1:0] cur_gx   = 9'd1;
  logic [gcne_pkg::DIM_W-1:0] cur_gy   = 9'd1;
  logic [gcne_pkg::DIM_W-1:0] cur_gz   = 9'd1;
  logic [2:0]                 cur_wrap = 3'd0;

  nb_result_t nb_expect_q[$];
  int         mismatches = 0;
  int         send_calm = 0;
  int         recv_calm = 0;
  bit         hold_go = 1'b0;
  bit         hold_done = 1'b0;

  grid_cell_neighbor_enumerator uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

  // mostly random waits, with occasional stretches of back-to-back traffic
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic bit step_axis(input int c, input int d, input int g, input bit wrap,
                                   output int res);
    res = c + d;
    if (res < 0) begin
      res = g - 1;
      return wrap;
    end
    if (res >= g) begin
      res = 0;
      return wrap;
    end
    return 1'b1;
  endfunction

  function automatic void enumerate_neighbors(input logic [gcne_pkg::RANK_W-1:0] req_rank);
    int         gx, gy, gz, plane, r, px, py, pz, nx, ny, nz, n, dx, dy, dz;
    bit         fits, ok;
    nb_result_t e;
    gx    = (cur_gx == '0) ? 1 : int'(cur_gx);
    gy    = (cur_gy == '0) ? 1 : int'(cur_gy);
    gz    = (cur_gz == '0) ? 1 : int'(cur_gz);
    plane = gx * gy;
    fits  = (plane * gz) <= gcne_pkg::MAX_CELLS;
    r     = int'(req_rank);
    px    = r % gx;
    py    = (r / gx) % gy;
    pz    = (r / plane) % gz;
    n     = 0;
    for (dz = -1; dz <= 1; dz++) begin
      for (dy = -1; dy <= 1; dy++) begin
        for (dx = -1; dx <= 1; dx++) begin
          nx = 0;
          ny = 0;
          nz = 0;
          ok = fits && step_axis(px, dx, gx, cur_wrap[0], nx)
                    && step_axis(py, dy, gy, cur_wrap[1], ny)
                    && step_axis(pz, dz, gz, cur_wrap[2], nz);
          e.slot    = gcne_pkg::SLOT_W'(n);
          e.rank    = ok ? gcne_pkg::RANK_W'(nz * plane + ny * gx + nx) : '0;
          e.present = ok;
          e.last    = (n == NUM_SLOTS - 1);
          nb_expect_q = {nb_expect_q, e};
          n++;
        end
      end
    end
  endfunction

  task automatic write_reg(input logic [gcne_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gcne_pkg::CFG_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // lowers the input and waits until all results are drained before writing
  task automatic set_grid(input logic [gcne_pkg::DIM_W-1:0] gx,
                          input logic [gcne_pkg::DIM_W-1:0] gy,
                          input logic [gcne_pkg::DIM_W-1:0] gz, input logic [2:0] wrap);
    s_tvalid <= 1'b0;
    while (nb_expect_q.size() != 0) @(posedge clk);
    @(posedge clk);
    write_reg(gcne_pkg::CFG_GRID_X, gx);
    write_reg(gcne_pkg::CFG_GRID_Y, gy);
    write_reg(gcne_pkg::CFG_GRID_Z, gz);
    write_reg(gcne_pkg::CFG_PERIODIC, gcne_pkg::CFG_W'(wrap));
    cfg_wen  <= 1'b0;
    cur_gx   = gx;
    cur_gy   = gy;
    cur_gz   = gz;
    cur_wrap = wrap;
  endtask

  task automatic offer_cell(input logic [gcne_pkg::RANK_W-1:0] req_rank);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= req_rank;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  initial begin
    dir_row_t                    row;
    nb_result_t                  e;
    int                          i, n, sent, mode, a, b, c, plen, k, total;
    logic [gcne_pkg::RANK_W-1:0] req_rank;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_N; i++) begin
      row = DIR_TAB[i];
      if (row.gx != cur_gx || row.gy != cur_gy || row.gz != cur_gz || row.wrap != cur_wrap)
        set_grid(row.gx, row.gy, row.gz, row.wrap);
      offer_cell(row.rank);
      if (row.typed) begin
        for (n = 0; n < NUM_SLOTS; n++) begin
          e = '{gcne_pkg::SLOT_W'(n), gcne_pkg::RANK_W'(0), row.mask[n],
                n == NUM_SLOTS - 1};
          nb_expect_q = {nb_expect_q, e};
        end
      end else begin
        enumerate_neighbors(row.rank);
      end
    end

    sent = 0;
    while (sent < RAND_ITEMS) begin
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        a = $urandom_range(0, 511);
        b = $urandom_range(0, 511);
        c = $urandom_range(0, 511);
      end else if (mode == 1) begin
        a = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
        b = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
        c = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
      end else begin
        a = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 256 : 16);
        b = $urandom_range(1, 256 / a);
        c = $urandom_range(1, 256 / (a * b));
      end
      if (mode >= 8)
        set_grid(gcne_pkg::DIM_W'(c), gcne_pkg::DIM_W'(a), gcne_pkg::DIM_W'(b),
                 3'($urandom_range(0, 7)));
      else if (mode >= 5)
        set_grid(gcne_pkg::DIM_W'(b), gcne_pkg::DIM_W'(c), gcne_pkg::DIM_W'(a),
                 3'($urandom_range(0, 7)));
      else
        set_grid(gcne_pkg::DIM_W'(a), gcne_pkg::DIM_W'(b), gcne_pkg::DIM_W'(c),
                 3'($urandom_range(0, 7)));
      total = ((cur_gx == '0) ? 1 : int'(cur_gx)) * ((cur_gy == '0) ? 1 : int'(cur_gy))
            * ((cur_gz == '0) ? 1 : int'(cur_gz));
      plen = $urandom_range(8, 30);
      // one long phase during which the output side holds off
      if (!hold_go && sent >= 40) begin
        plen    = 30;
        hold_go = 1'b1;
      end
      for (k = 0; k < plen && sent < RAND_ITEMS; k++) begin
        if (total <= gcne_pkg::MAX_CELLS && $urandom_range(0, 4) != 0)
          req_rank = gcne_pkg::RANK_W'($urandom_range(0, total - 1));
        else
          req_rank = gcne_pkg::RANK_W'($urandom_range(0, 255));
        offer_cell(req_rank);
        enumerate_neighbors(req_rank);
        sent++;
      end
    end

    s_tvalid <= 1'b0;
    while (nb_expect_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    int         stall;
    nb_result_t want;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      // one long hold-off so the input side backs up and stalls
      if (!hold_done && hold_go) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      if (nb_expect_q.size() == 0) begin
        $error("unexpected result: slot %0d rank %0d", m_tdata[4:0], m_tdata[12:5]);
        mismatches++;
      end else begin
        want = nb_expect_q.pop_front();
        if (m_tdata[4:0] !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, m_tdata[4:0]);
          mismatches++;
        end
        if (m_tdata[12:5] !== want.rank) begin
          $error("neighbor_rank: expected %0d, got %0d", want.rank, m_tdata[12:5]);
          mismatches++;
        end
        if (m_tuser !== want.present) begin
          $error("present: expected %0d, got %0d", want.present, m_tuser);
          mismatches++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_tlast);
          mismatches++;
        end
      end
    end
  end

endmodule

@@ files.f @@
rtl/core/gcne_pkg.sv
rtl/core/gcne_front.sv
rtl/core/gcne_queue.sv
rtl/core/gcne_back.sv
rtl/core/grid_cell_neighbor_enumerator.sv
sim/grid_cell_neighbor_enumerator_tb.sv
